>>> rtl/core/cprg_pkg.sv
package cprg_pkg;

  localparam int PIX_W           = 13;
  localparam int DIR_W           = 16;
  localparam int VEC_W           = 60;
  localparam int VP_W            = 24;
  localparam int CNT_W           = 14;
  localparam int APB_DW          = 64;
  localparam int APB_AW          = 6;
  localparam int FRAC_BITS       = 14;
  localparam int SIZE_FRAC_BITS  = 16;
  localparam int NORM_TOP        = 30;
  localparam int DIV_BPS         = 4;
  localparam int SQRT_SPS        = 2;

  localparam int COMPONENT_BITS_DEF = 20;
  localparam int RES_BITS_DEF       = 13;

  typedef enum logic [2:0] {
    REG_CORNER = 3'd0,
    REG_ORIGIN = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_UP     = 3'd3,
    REG_VP_W   = 3'd4,
    REG_VP_H   = 3'd5,
    REG_COLS   = 3'd6,
    REG_ROWS   = 3'd7
  } cfg_reg_e;

endpackage

>>> rtl/core/cprg_div.sv
// Pipelined restoring divider. The numerator must be below den_i * 2**Q_W,
// so only Q_W quotient bits are developed, BPS of them per stage.
module cprg_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 14,
  parameter int Q_W   = 40,
  parameter int BPS   = 4
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int STAGES = (Q_W + BPS - 1) / BPS;

  logic [DEN_W-1:0] rem_q  [STAGES];
  logic [Q_W-1:0]   acc_q  [STAGES];
  logic [DEN_W-1:0] den_q  [STAGES];
  logic [DEN_W-1:0] rem_in [STAGES];
  logic [Q_W-1:0]   acc_in [STAGES];
  logic [DEN_W-1:0] den_in [STAGES];

  // The accumulator shifts numerator bits out at the top and quotient bits in at the bottom.
  assign rem_in[0] = (Q_W < NUM_W) ? DEN_W'(num_i >> Q_W) : '0;
  assign acc_in[0] = num_i[Q_W-1:0];
  assign den_in[0] = den_i;

  for (genvar s = 1; s < STAGES; s++) begin : g_link
    assign rem_in[s] = rem_q[s-1];
    assign acc_in[s] = acc_q[s-1];
    assign den_in[s] = den_q[s-1];
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DEN_W-1:0] rem_d;
    logic [Q_W-1:0]   acc_d;

    always_comb begin
      logic [DEN_W:0] t;
      rem_d = rem_in[s];
      acc_d = acc_in[s];
      t     = '0;
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < Q_W) begin
          t = {rem_d, acc_d[Q_W-1]};
          if (t >= {1'b0, den_in[s]}) begin
            rem_d = DEN_W'(t - {1'b0, den_in[s]});
            acc_d = {acc_d[Q_W-2:0], 1'b1};
          end else begin
            rem_d = t[DEN_W-1:0];
            acc_d = {acc_d[Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      acc_q[s] <= acc_d;
      den_q[s] <= den_in[s];
    end
  end

  assign quo_o = acc_q[STAGES-1];

endmodule

>>> rtl/core/cprg_sqrt.sv
// Pipelined digit-by-digit integer square root, SPS result bits per stage.
module cprg_sqrt #(
  parameter int R_W = 31,
  parameter int SPS = 2
) (
  input  logic             clk_i,
  input  logic [2*R_W-1:0] rad_i,
  output logic [R_W-1:0]   root_o
);

  localparam int STAGES = (R_W + SPS - 1) / SPS;

  logic [R_W+1:0]   rem_q  [STAGES];
  logic [R_W-1:0]   root_q [STAGES];
  logic [2*R_W-1:0] acc_q  [STAGES];
  logic [R_W+1:0]   rem_in [STAGES];
  logic [R_W-1:0]   root_in[STAGES];
  logic [2*R_W-1:0] acc_in [STAGES];

  assign rem_in[0]  = '0;
  assign root_in[0] = '0;
  assign acc_in[0]  = rad_i;

  for (genvar s = 1; s < STAGES; s++) begin : g_link
    assign rem_in[s]  = rem_q[s-1];
    assign root_in[s] = root_q[s-1];
    assign acc_in[s]  = acc_q[s-1];
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [R_W+1:0]   rem_d;
    logic [R_W-1:0]   root_d;
    logic [2*R_W-1:0] acc_d;

    always_comb begin
      logic [R_W+3:0] t;
      logic [R_W+1:0] trial;
      rem_d  = rem_in[s];
      root_d = root_in[s];
      acc_d  = acc_in[s];
      t      = '0;
      trial  = '0;
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < R_W) begin
          t     = {rem_d, acc_d[2*R_W-1 -: 2]};
          trial = {root_d, 2'b01};
          acc_d = acc_d << 2;
          if (t >= (R_W+4)'(trial)) begin
            rem_d  = (R_W+2)'(t - (R_W+4)'(trial));
            root_d = {root_d[R_W-2:0], 1'b1};
          end else begin
            rem_d  = t[R_W+1:0];
            root_d = {root_d[R_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
      acc_q[s]  <= acc_d;
    end
  end

  assign root_o = root_q[STAGES-1];

endmodule

>>> rtl/core/camera_primary_ray_generator.sv
// Pinhole camera ray generator: one pixel word (pixel_x, pixel_y) may be started in every
// clock cycle and busy never rises. Each word yields one unit direction, shown on
// result_valid_o in start order; the receiver must take it in that cycle. The pipeline
// holds two pipelined dividers (screen offset by the pixel count, 4 quotient bits per
// stage, then the final scaling by the length) and the pipelined square root (2 root bits
// per stage). Camera registers must be written only while no word is in flight.
module camera_primary_ray_generator #(
  parameter int COMPONENT_BITS = cprg_pkg::COMPONENT_BITS_DEF,
  parameter int RES_BITS       = cprg_pkg::RES_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [cprg_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [cprg_pkg::PIX_W-1:0]   pixel_y_i,
  output logic                         result_valid_o,
  output logic signed [cprg_pkg::DIR_W-1:0] dir_x_o,
  output logic signed [cprg_pkg::DIR_W-1:0] dir_y_o,
  output logic signed [cprg_pkg::DIR_W-1:0] dir_z_o,
  output logic                         degenerate_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cprg_pkg::APB_AW-1:0]  paddr,
  input  logic [cprg_pkg::APB_DW-1:0]  pwdata,
  output logic [cprg_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  import cprg_pkg::*;

  localparam int CB    = COMPONENT_BITS;
  localparam int R     = RES_BITS;
  localparam int SX_W  = R + 26;
  localparam int PR_W  = SX_W + CB;
  localparam int NQ_W  = R + CB + 7;
  localparam int D_W   = NQ_W + 3;
  localparam int M_W   = NQ_W + 2;
  localparam int NG    = (M_W + 7) / 8;
  localparam int P_W   = $clog2(NG * 8);
  localparam int NM_W  = NORM_TOP;
  localparam int NORM  = NORM_TOP - 1;
  localparam int SQ_W  = 2 * NM_W + 2;
  localparam int RT_W  = NM_W + 1;
  localparam int N2_W  = NM_W + FRAC_BITS + 1;
  localparam int Q2_W  = FRAC_BITS + 1;
  localparam int DS1   = (NQ_W + DIV_BPS - 1) / DIV_BPS;
  localparam int DS2   = (RT_W + SQRT_SPS - 1) / SQRT_SPS;
  localparam int DS3   = (Q2_W + DIV_BPS - 1) / DIV_BPS;
  localparam int TOTAL = DS1 + DS2 + DS3 + 14;
  localparam int PSG_LEN = DS1 + 1;
  localparam int DSG_LEN = DS2 + DS3 + 8;
  localparam int DEG_LEN = DS2 + DS3 + 5;
  localparam int NM_LEN  = DS2 + 3;
  localparam logic [Q2_W-1:0] ONE = Q2_W'(1) << FRAC_BITS;

  // Configuration registers.
  logic [VEC_W-1:0]       corner_q, origin_q, right_q, up_q;
  logic signed [VP_W-1:0] vpw_q, vph_q;
  logic [CNT_W-1:0]       cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      origin_q <= '0;
      right_q  <= '0;
      up_q     <= '0;
      vpw_q    <= '0;
      vph_q    <= '0;
      cols_q   <= CNT_W'(1);
      rows_q   <= CNT_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (cfg_reg_e'(paddr[5:3]))
        REG_CORNER: corner_q <= pwdata[VEC_W-1:0];
        REG_ORIGIN: origin_q <= pwdata[VEC_W-1:0];
        REG_RIGHT:  right_q  <= pwdata[VEC_W-1:0];
        REG_UP:     up_q     <= pwdata[VEC_W-1:0];
        REG_VP_W:   vpw_q    <= pwdata[VP_W-1:0];
        REG_VP_H:   vph_q    <= pwdata[VP_W-1:0];
        REG_COLS:   cols_q   <= pwdata[CNT_W-1:0];
        REG_ROWS:   rows_q   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_e'(paddr[5:3]))
      REG_CORNER: prdata = APB_DW'(corner_q);
      REG_ORIGIN: prdata = APB_DW'(origin_q);
      REG_RIGHT:  prdata = APB_DW'(right_q);
      REG_UP:     prdata = APB_DW'(up_q);
      REG_VP_W:   prdata = APB_DW'(unsigned'(vpw_q));
      REG_VP_H:   prdata = APB_DW'(unsigned'(vph_q));
      REG_COLS:   prdata = APB_DW'(cols_q);
      REG_ROWS:   prdata = APB_DW'(rows_q);
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // Unpacked components; a component beyond the stored 60 bits reads as zero.
  logic [3*CB-1:0] cor_ext, ori_ext, rgt_ext, up_ext;
  logic signed [CB-1:0] cor_c [3];
  logic signed [CB-1:0] ori_c [3];
  logic signed [CB-1:0] rgt_c [3];
  logic signed [CB-1:0] up_c  [3];
  logic signed [CB:0]   co_q  [3];
  logic [CNT_W-1:0] cols_eff, rows_eff;

  assign cor_ext  = (3*CB)'(corner_q);
  assign ori_ext  = (3*CB)'(origin_q);
  assign rgt_ext  = (3*CB)'(right_q);
  assign up_ext   = (3*CB)'(up_q);
  assign cols_eff = (cols_q == '0) ? CNT_W'(1) : cols_q;
  assign rows_eff = (rows_q == '0) ? CNT_W'(1) : rows_q;

  for (genvar k = 0; k < 3; k++) begin : g_comp
    assign cor_c[k] = $signed(cor_ext[k*CB +: CB]);
    assign ori_c[k] = $signed(ori_ext[k*CB +: CB]);
    assign rgt_c[k] = $signed(rgt_ext[k*CB +: CB]);
    assign up_c[k]  = $signed(up_ext[k*CB +: CB]);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      co_q[k] <= (CB+1)'(cor_c[k]) - (CB+1)'(ori_c[k]);
    end
  end

  // Valid bits travel alongside the data stages.
  logic [TOTAL-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOTAL-2:0], start && !busy};
    end
  end

  // Stage 1: screen offsets scaled by the viewport size.
  logic [R-1:0] px, py;
  logic signed [SX_W-1:0] sx_q, sy_q;

  assign px = R'(pixel_x_i);
  assign py = R'(pixel_y_i);

  always_ff @(posedge clk_i) begin
    sx_q <= $signed({1'b0, px, 1'b1}) * vpw_q;
    sy_q <= $signed({1'b0, py, 1'b1}) * vph_q;
  end

  // Stage 2: axis products; terms 0..2 use the right axis, 3..5 the up axis.
  logic signed [PR_W-1:0] prod_q [6];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k]   <= sx_q * rgt_c[k];
      prod_q[k+3] <= sy_q * up_c[k];
    end
  end

  // Stage 3: magnitude plus half the divisor, pre-divided by the power of two.
  logic [NQ_W-1:0]  num1_q [6];
  logic [CNT_W-1:0] den1   [6];
  logic [5:0]       psg_d;
  logic [5:0]       psg_q [PSG_LEN];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      den1[i]  = (i < 3) ? cols_eff : rows_eff;
      psg_d[i] = prod_q[i][PR_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [PR_W-1:0] mg;
    logic [PR_W-1:0] a;
    for (int i = 0; i < 6; i++) begin
      mg = psg_d[i] ? PR_W'(-prod_q[i]) : PR_W'(prod_q[i]);
      a  = mg + (PR_W'(den1[i]) << SIZE_FRAC_BITS);
      num1_q[i] <= a[SIZE_FRAC_BITS+1 +: NQ_W];
    end
    psg_q[0] <= psg_d;
    for (int i = 1; i < PSG_LEN; i++) begin
      psg_q[i] <= psg_q[i-1];
    end
  end

  logic [NQ_W-1:0] quo1 [6];

  for (genvar i = 0; i < 6; i++) begin : g_div1
    cprg_div #(
      .NUM_W(NQ_W),
      .DEN_W(CNT_W),
      .Q_W  (NQ_W),
      .BPS  (DIV_BPS)
    ) u_div (
      .clk_i(clk_i),
      .num_i(num1_q[i]),
      .den_i(den1[i]),
      .quo_o(quo1[i])
    );
  end

  // Signed terms, then the exact sum with corner minus origin.
  logic signed [D_W-1:0] t_q [6];
  logic signed [D_W-1:0] d_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      t_q[i] <= psg_q[PSG_LEN-1][i] ? -$signed(D_W'(quo1[i])) : $signed(D_W'(quo1[i]));
    end
    for (int k = 0; k < 3; k++) begin
      d_q[k] <= D_W'(co_q[k]) + t_q[k] + t_q[k+3];
    end
  end

  // Magnitudes, their maximum and a grouped leading-one search.
  logic [M_W-1:0] m6_q [3];
  logic [M_W-1:0] m7_q [3];
  logic [M_W-1:0] m8_q [3];
  logic [M_W-1:0] m9_q [3];
  logic [2:0]     dsg_d;
  logic [2:0]     dsg_q [DSG_LEN];
  logic [M_W-1:0] mx_q;
  logic [NG-1:0]  nz_q;
  logic [2:0]     pos_q [NG];
  logic [P_W-1:0] p_q;
  logic           deg_d;
  logic           deg_q [DEG_LEN];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsg_d[k] = d_q[k][D_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [M_W-1:0]    mx;
    logic [NG*8-1:0]   pad;
    logic [2:0]        ps;
    logic [P_W-1:0]    pp;
    for (int k = 0; k < 3; k++) begin
      m6_q[k] <= dsg_d[k] ? M_W'(-d_q[k]) : M_W'(d_q[k]);
    end
    dsg_q[0] <= dsg_d;
    for (int i = 1; i < DSG_LEN; i++) begin
      dsg_q[i] <= dsg_q[i-1];
    end

    mx = m6_q[0];
    if (m6_q[1] > mx) mx = m6_q[1];
    if (m6_q[2] > mx) mx = m6_q[2];
    mx_q <= mx;
    m7_q <= m6_q;

    pad = (NG*8)'(mx_q);
    for (int g = 0; g < NG; g++) begin
      ps = '0;
      for (int b = 0; b < 8; b++) begin
        if (pad[g*8+b]) ps = 3'(b);
      end
      nz_q[g]  <= |pad[g*8 +: 8];
      pos_q[g] <= ps;
    end
    m8_q <= m7_q;

    pp = '0;
    for (int g = 0; g < NG; g++) begin
      if (nz_q[g]) pp = P_W'(g * 8) + P_W'(pos_q[g]);
    end
    p_q  <= pp;
    m9_q <= m8_q;
  end

  assign deg_d = ~|nz_q;

  always_ff @(posedge clk_i) begin
    deg_q[0] <= deg_d;
    for (int i = 1; i < DEG_LEN; i++) begin
      deg_q[i] <= deg_q[i-1];
    end
  end

  // Common shift that brings the largest magnitude into [2**29, 2**30).
  logic [NM_W-1:0] nm_d  [3];
  logic [NM_W-1:0] nm_q  [NM_LEN][3];
  logic [2*NM_W-1:0] sq_q [3];
  logic [SQ_W-1:0] s_q;

  always_comb begin
    int pi;
    logic [NM_W+M_W-1:0] wide;
    pi   = int'(p_q);
    wide = '0;
    for (int k = 0; k < 3; k++) begin
      if (pi >= NORM) begin
        nm_d[k] = NM_W'(m9_q[k] >> (pi - NORM));
      end else begin
        wide    = {NM_W'(0), m9_q[k]} << (NORM - pi);
        nm_d[k] = wide[NM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nm_q[0] <= nm_d;
    for (int i = 1; i < NM_LEN; i++) begin
      nm_q[i] <= nm_q[i-1];
    end
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= nm_q[0][k] * nm_q[0][k];
    end
    s_q <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
  end

  logic [RT_W-1:0] root;

  cprg_sqrt #(
    .R_W(RT_W),
    .SPS(SQRT_SPS)
  ) u_sqrt (
    .clk_i (clk_i),
    .rad_i (s_q),
    .root_o(root)
  );

  // Scale each magnitude by the length, rounded to nearest.
  logic [N2_W-1:0] num2_q [3];
  logic [RT_W-1:0] len_q;
  logic [Q2_W-1:0] quo2   [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      num2_q[k] <= (N2_W'(nm_q[NM_LEN-1][k]) << FRAC_BITS) + N2_W'(root >> 1);
    end
    len_q <= root;
  end

  for (genvar k = 0; k < 3; k++) begin : g_div2
    cprg_div #(
      .NUM_W(N2_W),
      .DEN_W(RT_W),
      .Q_W  (Q2_W),
      .BPS  (DIV_BPS)
    ) u_div (
      .clk_i(clk_i),
      .num_i(num2_q[k]),
      .den_i(len_q),
      .quo_o(quo2[k])
    );
  end

  // Output register.
  logic signed [DIR_W-1:0] dir_q [3];
  logic                    deg_out_q;

  always_ff @(posedge clk_i) begin
    logic [Q2_W-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = (quo2[k] > ONE) ? ONE : quo2[k];
      if (deg_q[DEG_LEN-1]) begin
        dir_q[k] <= '0;
      end else if (dsg_q[DSG_LEN-1][k]) begin
        dir_q[k] <= -$signed(DIR_W'(q));
      end else begin
        dir_q[k] <= $signed(DIR_W'(q));
      end
    end
    deg_out_q <= deg_q[DEG_LEN-1];
  end

  assign result_valid_o = vld_q[TOTAL-1];
  assign dir_x_o        = dir_q[0];
  assign dir_y_o        = dir_q[1];
  assign dir_z_o        = dir_q[2];
  assign degenerate_o   = deg_out_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(TOTAL) result_valid_o)
    else $error("started word did not come out after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, TOTAL))
    else $error("result word without a matching start");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |-> (dir_x_o == '0 && dir_y_o == '0 && dir_z_o == '0))
    else $error("degenerate result with a nonzero direction");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (dir_x_o <= 16'sd16384 && dir_x_o >= -16'sd16384 &&
                        dir_y_o <= 16'sd16384 && dir_y_o >= -16'sd16384 &&
                        dir_z_o <= 16'sd16384 && dir_z_o >= -16'sd16384))
    else $error("direction component outside the unit range");

endmodule
